FILE: src/lnv_pkg.sv
// Shared types and constants for the layer normalization vector unit.
package lnv_pkg;

   localparam int DATA_W   = 16;  // Q8.8 sample, shift and result; Q4.12 scale
   localparam int NCNT_W   = 7;   // element count as carried to the datapath
   localparam int ADDR_MAX = 6;   // widest store address
   localparam int ITER_W   = 5;
   localparam logic [ITER_W-1:0] ITER_LAST = 5'd31;  // 32 steps for root and quotient

   typedef struct packed {
      logic                wr_en;
      logic                acc_sum;
      logic                clear;
      logic [ADDR_MAX-1:0] addr;
      logic [NCNT_W-1:0]   n;
      logic                dropped;
      logic                last;
      logic                rd;
      logic                dev;
      logic                sq;
      logic                acc;
      logic                q_clear;
      logic                eps1;
      logic                eps2;
      logic                eps3;
      logic                var_calc;
      logic                scale_w;
      logic                norm_step;
      logic                sqrt_init;
      logic                sqrt_step;
      logic                num;
      logic                shift;
      logic                div_step;
      logic                mul;
      logic                emit;
   } cmd_type;

   typedef struct packed {
      logic v_zero;
      logic w_norm;
      logic s_zero;
   } status_type;

endpackage

FILE: src/layer_normalization_vector_unit.sv
// Top level of the layer normalization vector unit.
//
//  channel  ports                                   handshake
//  request  req_sample req_scale req_shift req_last_in  start high, busy low
//  result   rsp_normalized rsp_last_out rsp_truncated   rsp_valid, one cycle
//  config   csr_wr_data                              csr_wr_en
//
// Loading takes one request per cycle while busy is low. After the last
// request a variance pass, the 32-step integer root (skipped at zero
// variance) and an output pass through the 32-step divider follow; at zero
// variance each result goes out straight after its deviation is formed.
// Reset is synchronous and clears the count, sum and eps; busy drops in the
// cycle that shows the final result. Results cannot be stalled.
module layer_normalization_vector_unit #(
   parameter int VEC_LEN = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [lnv_pkg::DATA_W-1:0] req_sample,
   input  logic signed [lnv_pkg::DATA_W-1:0] req_scale,
   input  logic signed [lnv_pkg::DATA_W-1:0] req_shift,
   input  logic                              req_last_in,
   output logic                              rsp_valid,
   output logic signed [lnv_pkg::DATA_W-1:0] rsp_normalized,
   output logic                              rsp_last_out,
   output logic                              rsp_truncated,
   input  logic                              csr_wr_en,
   input  logic [lnv_pkg::DATA_W-1:0]        csr_wr_data
);

   lnv_pkg::cmd_type    cmd;
   lnv_pkg::status_type status;

   lnv_ctrl #(.VEC_LEN(VEC_LEN)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .last_in (req_last_in),
      .busy    (busy),
      .cmd     (cmd),
      .status  (status)
   );

   lnv_dp #(.VEC_LEN(VEC_LEN)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_sample),
      .req_scale      (req_scale),
      .req_shift      (req_shift),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_normalized (rsp_normalized),
      .rsp_last_out   (rsp_last_out),
      .rsp_truncated  (rsp_truncated)
   );

endmodule

FILE: src/lnv_ctrl.sv
// Sequencer for loading, variance, root, division and output passes.
module lnv_ctrl #(
   parameter int VEC_LEN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 last_in,
   output logic                 busy,
   output lnv_pkg::cmd_type     cmd,
   input  lnv_pkg::status_type  status
);

   localparam int CNT_W = $clog2(VEC_LEN + 1);

   typedef enum logic [4:0] {
      S_LOAD, S_P1_RD, S_P1_DEV, S_P1_SQ, S_P1_ACC,
      S_EPS1, S_EPS2, S_EPS3, S_VAR, S_SCALEW, S_NORM, S_SQRT,
      S_P2_RD, S_P2_DEV, S_P2_NUM, S_P2_SHIFT, S_P2_DIV, S_P2_MUL, S_P2_EMIT
   } state_type;

   state_type                  state_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           idx_ff;
   logic [lnv_pkg::ITER_W-1:0] iter_ff;
   logic                       dropped_ff;
   logic                       has_room;
   logic                       last_elem;

   assign busy      = (state_ff != S_LOAD);
   assign has_room  = (count_ff < CNT_W'(VEC_LEN));
   assign last_elem = (idx_ff == CNT_W'(count_ff - 1'b1));

   always_comb begin
      cmd         = '0;
      cmd.n       = lnv_pkg::NCNT_W'(count_ff);
      cmd.dropped = dropped_ff;
      cmd.last    = last_elem;
      cmd.addr    = (state_ff == S_LOAD) ? lnv_pkg::ADDR_MAX'(count_ff)
                                         : lnv_pkg::ADDR_MAX'(idx_ff);
      unique case (state_ff)
         S_LOAD: begin
            cmd.wr_en   = start && has_room;
            cmd.acc_sum = start && has_room;
            cmd.q_clear = start && last_in;
         end
         S_P1_RD, S_P2_RD: cmd.rd = 1'b1;
         S_P1_DEV, S_P2_DEV: cmd.dev = 1'b1;
         S_P1_SQ:    cmd.sq = 1'b1;
         S_P1_ACC:   cmd.acc = 1'b1;
         S_EPS1:     cmd.eps1 = 1'b1;
         S_EPS2:     cmd.eps2 = 1'b1;
         S_EPS3:     cmd.eps3 = 1'b1;
         S_VAR:      cmd.var_calc = 1'b1;
         S_SCALEW: begin
            cmd.scale_w   = 1'b1;
            cmd.sqrt_init = 1'b1;
         end
         S_NORM:     cmd.norm_step = !status.w_norm;
         S_SQRT:     cmd.sqrt_step = 1'b1;
         S_P2_NUM:   cmd.num = 1'b1;
         S_P2_SHIFT: cmd.shift = 1'b1;
         S_P2_DIV:   cmd.div_step = 1'b1;
         S_P2_MUL:   cmd.mul = 1'b1;
         S_P2_EMIT: begin
            cmd.emit  = 1'b1;
            cmd.clear = last_elem;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         idx_ff     <= '0;
         iter_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (start) begin
                  if (has_room) count_ff <= CNT_W'(count_ff + 1'b1);
                  else dropped_ff <= 1'b1;
                  if (last_in) begin
                     idx_ff   <= '0;
                     state_ff <= S_P1_RD;
                  end
               end
            end
            S_P1_RD:  state_ff <= S_P1_DEV;
            S_P1_DEV: state_ff <= S_P1_SQ;
            S_P1_SQ:  state_ff <= S_P1_ACC;
            S_P1_ACC: begin
               if (last_elem) state_ff <= S_EPS1;
               else begin
                  idx_ff   <= CNT_W'(idx_ff + 1'b1);
                  state_ff <= S_P1_RD;
               end
            end
            S_EPS1: state_ff <= S_EPS2;
            S_EPS2: state_ff <= S_EPS3;
            S_EPS3: state_ff <= S_VAR;
            S_VAR:  state_ff <= S_SCALEW;
            S_SCALEW: begin
               idx_ff <= '0;
               // zero variance: skip the root, every result is its shift
               if (status.v_zero) state_ff <= S_P2_RD;
               else state_ff <= S_NORM;
            end
            S_NORM: begin
               if (status.w_norm) begin
                  iter_ff  <= '0;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (iter_ff == lnv_pkg::ITER_LAST) state_ff <= S_P2_RD;
               else iter_ff <= iter_ff + 1'b1;
            end
            S_P2_RD: state_ff <= S_P2_DEV;
            S_P2_DEV: begin
               if (status.s_zero) state_ff <= S_P2_EMIT;
               else state_ff <= S_P2_NUM;
            end
            S_P2_NUM: state_ff <= S_P2_SHIFT;
            S_P2_SHIFT: begin
               iter_ff  <= '0;
               state_ff <= S_P2_DIV;
            end
            S_P2_DIV: begin
               if (iter_ff == lnv_pkg::ITER_LAST) state_ff <= S_P2_MUL;
               else iter_ff <= iter_ff + 1'b1;
            end
            S_P2_MUL: state_ff <= S_P2_EMIT;
            S_P2_EMIT: begin
               if (last_elem) begin
                  count_ff   <= '0;
                  dropped_ff <= 1'b0;
                  state_ff   <= S_LOAD;
               end else begin
                  idx_ff   <= CNT_W'(idx_ff + 1'b1);
                  state_ff <= S_P2_RD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && last_in))
      else $error("busy rose without a last request");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VEC_LEN))
      else $error("element count beyond capacity");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (idx_ff < count_ff))
      else $error("element index beyond stored count");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P2_EMIT && last_elem) |=> (!busy && count_ff == '0))
      else $error("vector end did not return to load");
`endif

endmodule

FILE: src/lnv_dp.sv
// Datapath: element store, sums, integer root, divider and output stage.
module lnv_dp #(
   parameter int VEC_LEN = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lnv_pkg::cmd_type                  cmd,
   output lnv_pkg::status_type               status,
   input  logic signed [lnv_pkg::DATA_W-1:0] req_sample,
   input  logic signed [lnv_pkg::DATA_W-1:0] req_scale,
   input  logic signed [lnv_pkg::DATA_W-1:0] req_shift,
   input  logic                              csr_wr_en,
   input  logic [lnv_pkg::DATA_W-1:0]        csr_wr_data,
   output logic                              rsp_valid,
   output logic signed [lnv_pkg::DATA_W-1:0] rsp_normalized,
   output logic                              rsp_last_out,
   output logic                              rsp_truncated
);

   localparam int ADDR_W = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;

   logic [47:0]        mem_ff [VEC_LEN];
   logic [47:0]        rd_ff;
   logic signed [22:0] sum_ff;
   logic [15:0]        eps_ff;
   logic signed [23:0] d_ff;
   logic [44:0]        sq_ff;
   logic [51:0]        q_ff;
   logic [34:0]        e_ff;
   logic [51:0]        v_ff;
   logic [63:0]        w_ff;
   logic [4:0]         k_ff;
   logic [63:0]        res_ff;
   logic [63:0]        bit_ff;
   logic [29:0]        dmn_ff;
   logic               neg_ff;
   logic [32:0]        rem_ff;
   logic [31:0]        lo_ff;
   logic [31:0]        quot_ff;
   logic [47:0]        p_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_y_ff;
   logic               rsp_last_ff;
   logic               rsp_trunc_ff;

   logic signed [15:0] x_rd, g_rd, b_rd;
   logic signed [7:0]  n_s;
   logic signed [23:0] nx;
   logic signed [47:0] sq_full;
   logic [63:0]        trial_sq;
   logic [23:0]        dm;
   logic [63:0]        sh;
   logic [5:0]         sh_amt;
   logic [32:0]        trial_div;
   logic [15:0]        gm;
   logic [47:0]        rnd;
   logic [19:0]        mag;
   logic signed [21:0] y_wide;
   logic signed [15:0] y_sat;

   assign x_rd     = rd_ff[47:32];
   assign g_rd     = rd_ff[31:16];
   assign b_rd     = rd_ff[15:0];
   assign n_s      = {1'b0, cmd.n};
   assign nx       = n_s * x_rd;
   assign sq_full  = d_ff * d_ff;
   assign trial_sq = res_ff + bit_ff;
   assign dm       = d_ff[23] ? 24'(-d_ff) : d_ff;
   assign sh_amt   = 6'(k_ff) + 6'd24;
   assign sh       = {34'd0, dmn_ff} << sh_amt;
   assign trial_div = {rem_ff[31:0], lo_ff[31]};
   assign gm       = g_rd[15] ? 16'(~g_rd + 16'd1) : g_rd;
   assign rnd      = p_ff + 48'h000_0800_0000;
   assign mag      = rnd[47:28];

   always_comb begin
      if (status.s_zero) y_wide = 22'(b_rd);
      else if (neg_ff) y_wide = 22'(b_rd) - $signed({2'b00, mag});
      else y_wide = 22'(b_rd) + $signed({2'b00, mag});
      // saturate to Q8.8
      priority if (y_wide > 22'sd32767) y_sat = 16'sh7fff;
      else if (y_wide < -22'sd32768) y_sat = 16'sh8000;
      else y_sat = y_wide[15:0];
   end

   assign status.v_zero = (v_ff == '0);
   assign status.w_norm = |w_ff[61:60];
   assign status.s_zero = (res_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem_ff[cmd.addr[ADDR_W-1:0]] <= {req_sample, req_scale, req_shift};
      if (cmd.rd) rd_ff <= mem_ff[cmd.addr[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         eps_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) eps_ff <= csr_wr_data;
         if (cmd.clear) sum_ff <= '0;
         else if (cmd.acc_sum) sum_ff <= sum_ff + 23'(req_sample);
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dev) d_ff <= nx - 24'(sum_ff);
      if (cmd.sq) sq_ff <= sq_full[44:0];
      if (cmd.q_clear) q_ff <= '0;
      else if (cmd.acc) q_ff <= q_ff + 52'(sq_ff);
      if (cmd.eps1) e_ff <= 35'(cmd.n * cmd.n);
      else if (cmd.eps2) e_ff <= 35'(e_ff[12:0] * cmd.n);
      else if (cmd.eps3) e_ff <= 35'(e_ff[18:0] * eps_ff);
      if (cmd.var_calc) v_ff <= q_ff + 52'(e_ff);
      if (cmd.scale_w) begin
         w_ff <= 64'(v_ff * cmd.n);
         k_ff <= '0;
      end else if (cmd.norm_step) begin
         w_ff <= w_ff << 2;
         k_ff <= k_ff + 1'b1;
      end else if (cmd.sqrt_step && w_ff >= trial_sq) begin
         w_ff <= w_ff - trial_sq;
      end
      if (cmd.sqrt_init) begin
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (cmd.sqrt_step) begin
         if (w_ff >= trial_sq) res_ff <= (res_ff >> 1) + bit_ff;
         else res_ff <= res_ff >> 1;
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.num) begin
         dmn_ff <= 30'(dm[22:0] * cmd.n);
         neg_ff <= d_ff[23] ^ g_rd[15];
      end
      if (cmd.shift) begin
         rem_ff  <= {1'b0, sh[63:32]};
         lo_ff   <= sh[31:0];
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         if (trial_div >= {1'b0, res_ff[31:0]}) begin
            rem_ff  <= trial_div - {1'b0, res_ff[31:0]};
            quot_ff <= {quot_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= trial_div;
            quot_ff <= {quot_ff[30:0], 1'b0};
         end
         lo_ff <= lo_ff << 1;
      end
      if (cmd.mul) p_ff <= quot_ff * gm;
      if (cmd.emit) begin
         rsp_y_ff     <= y_sat;
         rsp_last_ff  <= cmd.last;
         rsp_trunc_ff <= cmd.dropped;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normalized = rsp_y_ff;
   assign rsp_last_out   = rsp_last_ff;
   assign rsp_truncated  = rsp_trunc_ff;

endmodule
